// ===== hdl/axs_pkg.sv =====
package axs_pkg;

    localparam int AXIS_W      = 16;
    localparam int DT_W        = 16;
    localparam int SPD_W       = 16;
    localparam int LVL_EXT_W   = AXIS_W + 1;
    localparam int W_W         = 17;
    localparam int MUL_A_W     = 16;
    localparam int MUL_B_W     = 21;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W   = $clog2(MUL_A_W);
    localparam int W_SHIFT     = 9;
    localparam int W_RAW_W     = MUL_P_W - W_SHIFT;
    localparam int STEP_LSB    = 16;
    localparam int ROUND_BIT   = STEP_LSB - 1;
    localparam int CFG_DATA_W  = 32;
    localparam int PADDR_W     = 3;
    localparam int REG_IDX_BIT = 2;

    localparam logic [SPD_W-1:0] SPEED_RESET = 16'd256;
    localparam logic [W_W-1:0]   W_ONE       = 17'h10000;

    localparam logic signed [LVL_EXT_W-1:0] TGT_POS  = 17'sd16384;
    localparam logic signed [LVL_EXT_W-1:0] TGT_NEG  = -17'sd16384;
    localparam logic signed [LVL_EXT_W-1:0] TGT_ZERO = 17'sd0;
    localparam logic signed [AXIS_W-1:0]    DEAD_ZONE = 16'sd16;

    localparam logic [0:0] REG_RISE  = 1'b0;
    localparam logic [0:0] REG_DECAY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WSTART,
        ST_WWAIT,
        ST_PICK,
        ST_BSTART,
        ST_BWAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic [MUL_P_W-1:0] product;
    } t_mul_rsp;

    typedef struct packed {
        logic [SPD_W-1:0] rise_speed;
        logic [SPD_W-1:0] decay_speed;
    } t_cfg;

endpackage

// ===== hdl/axs_if.sv =====
interface axs_in_if import axs_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            pos_key_pressed;
    logic            neg_key_pressed;
    logic            pos_button_pressed;
    logic            neg_button_pressed;
    logic [DT_W-1:0] delta_time;

    modport source (
        output valid, pos_key_pressed, neg_key_pressed,
        output pos_button_pressed, neg_button_pressed, delta_time,
        input  ready
    );
    modport sink (
        input  valid, pos_key_pressed, neg_key_pressed,
        input  pos_button_pressed, neg_button_pressed, delta_time,
        output ready
    );
endinterface

interface axs_out_if import axs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [AXIS_W-1:0] axis_value;

    modport source (output valid, axis_value, input ready);
    modport sink (input valid, axis_value, output ready);
endinterface

// ===== hdl/axis_input_smoother.sv =====
// Smooths one input axis per frame tick. Each request carries four pressed
// flags and the tick time; one result with the new axis level (signed Q2.14)
// follows. Pressed flags pull the level toward +1 or -1 in the order positive
// key, negative key, positive button, negative button, using the rise speed;
// with no flag set it decays toward zero using the decay speed, and a level
// within 16 LSB of zero reads as zero. The weight and every blend go through
// one shared bit-serial multiplier, so a request takes one weight product and
// one blend per pressed flag, or one decay blend with none set. One request is
// in work at a time; a finished result waits in the output register while the
// next request is taken. rise_speed lies at byte address 0 and decay_speed at
// 4 (unsigned Q8.8, reset 1.0); write them only while no request is in work.
module axis_input_smoother import axs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    axs_in_if.sink                i_req,
    axs_out_if.source             o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg     cfg;
    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    axs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    axs_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    axs_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_mul_req (mul_req),
        .i_mul_rsp (mul_rsp)
    );

endmodule

// ===== hdl/axs_cfg_regs.sv =====
module axs_cfg_regs import axs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [SPD_W-1:0] r_rise;
    logic [SPD_W-1:0] r_decay;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise  <= SPEED_RESET;
            r_decay <= SPEED_RESET;
        end else if (wr_en) begin
            case (paddr[REG_IDX_BIT])
                REG_RISE:  r_rise  <= pwdata[SPD_W-1:0];
                REG_DECAY: r_decay <= pwdata[SPD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[REG_IDX_BIT])
            REG_RISE:  prdata = {{(CFG_DATA_W-SPD_W){1'b0}}, r_rise};
            REG_DECAY: prdata = {{(CFG_DATA_W-SPD_W){1'b0}}, r_decay};
            default:   prdata = '0;
        endcase
    end

    assign o_cfg.rise_speed  = r_rise;
    assign o_cfg.decay_speed = r_decay;

endmodule

// ===== hdl/axs_serial_mul.sv =====
module axs_serial_mul import axs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    // shift-add, one multiplier bit per cycle, LSB first
    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [MUL_A_W-1:0]   r_a;
    logic [MUL_B_W-1:0]   r_b;
    logic [MUL_B_W:0]     r_hi;
    logic [MUL_A_W-1:0]   r_lo;
    logic [MUL_B_W:0]     sum;

    assign sum = r_hi + (r_a[0] ? {1'b0, r_b} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CNT_W'(MUL_A_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a  <= i_req.a;
            r_b  <= i_req.b;
            r_hi <= '0;
            r_lo <= '0;
        end else if (r_busy) begin
            r_a  <= r_a >> 1;
            r_hi <= {1'b0, sum[MUL_B_W:1]};
            r_lo <= {sum[0], r_lo[MUL_A_W-1:1]};
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = {r_hi[MUL_B_W-1:0], r_lo};

endmodule

// ===== hdl/axs_core.sv =====
module axs_core import axs_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    axs_in_if.sink        i_req,
    axs_out_if.source     o_rsp,
    output t_mul_req      o_mul_req,
    input  t_mul_rsp      i_mul_rsp
);

    t_state                   r_state, n_state;
    logic signed [AXIS_W-1:0] r_level, n_level;
    logic [3:0]               r_todo, n_todo;
    logic                     r_decay, n_decay;
    logic [DT_W-1:0]          r_dt, n_dt;
    logic [MUL_B_W-1:0]       r_s25, n_s25;
    logic [W_W-1:0]           r_w, n_w;
    logic                     r_neg, n_neg;
    logic [MUL_A_W-1:0]       r_mag, n_mag;
    logic                     r_out_valid, n_out_valid;
    logic signed [AXIS_W-1:0] r_out_value, n_out_value;

    logic [SPD_W-1:0]            speed;
    logic [MUL_B_W-1:0]          speed_ext;
    logic [W_RAW_W-1:0]          w_raw;
    logic signed [LVL_EXT_W-1:0] target;
    logic signed [LVL_EXT_W-1:0] level_ext;
    logic signed [LVL_EXT_W-1:0] diff;
    logic [LVL_EXT_W-1:0]        diff_abs;
    logic [W_W-1:0]              step;
    logic [LVL_EXT_W-1:0]        level_new;
    logic signed [AXIS_W-1:0]    snapped;
    logic                        any_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_todo      <= n_todo;
        r_decay     <= n_decay;
        r_dt        <= n_dt;
        r_s25       <= n_s25;
        r_w         <= n_w;
        r_neg       <= n_neg;
        r_mag       <= n_mag;
        r_out_value <= n_out_value;
    end

    assign any_flag  = i_req.pos_key_pressed || i_req.neg_key_pressed ||
                       i_req.pos_button_pressed || i_req.neg_button_pressed;
    assign speed     = any_flag ? i_cfg.rise_speed : i_cfg.decay_speed;
    assign speed_ext = {{(MUL_B_W-SPD_W){1'b0}}, speed};
    assign w_raw     = i_mul_rsp.product[MUL_P_W-1:W_SHIFT];

    // product bits past the binary point round half up on the magnitude
    assign step = i_mul_rsp.product[STEP_LSB+W_W-1:STEP_LSB]
                + {{(W_W-1){1'b0}}, i_mul_rsp.product[ROUND_BIT]};

    assign level_ext = {r_level[AXIS_W-1], r_level};
    assign level_new = r_neg ? (level_ext - step) : (level_ext + step);
    assign snapped   = (r_level >= -DEAD_ZONE && r_level <= DEAD_ZONE) ? '0 : r_level;

    always_comb begin
        if (r_todo[0])      target = TGT_POS;
        else if (r_todo[1]) target = TGT_NEG;
        else if (r_todo[2]) target = TGT_POS;
        else if (r_todo[3]) target = TGT_NEG;
        else                target = TGT_ZERO;
    end

    assign diff     = target - level_ext;
    assign diff_abs = diff[LVL_EXT_W-1] ? -diff : diff;

    always_comb begin
        n_state     = r_state;
        n_level     = r_level;
        n_todo      = r_todo;
        n_decay     = r_decay;
        n_dt        = r_dt;
        n_s25       = r_s25;
        n_w         = r_w;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        o_mul_req   = '0;
        i_req.ready = 1'b0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_todo  = {i_req.neg_button_pressed, i_req.pos_button_pressed,
                               i_req.neg_key_pressed, i_req.pos_key_pressed};
                    n_decay = !any_flag;
                    n_dt    = i_req.delta_time;
                    n_s25   = (speed_ext << 4) + (speed_ext << 3) + speed_ext;
                    n_state = ST_WSTART;
                end
            end
            ST_WSTART: begin
                o_mul_req.start = 1'b1;
                o_mul_req.a     = r_dt;
                o_mul_req.b     = r_s25;
                n_state         = ST_WWAIT;
            end
            ST_WWAIT: begin
                if (i_mul_rsp.done) begin
                    n_w = (w_raw > {{(W_RAW_W-W_W){1'b0}}, W_ONE}) ? W_ONE
                                                                  : w_raw[W_W-1:0];
                    n_state = ST_PICK;
                end
            end
            ST_PICK: begin
                if (r_todo != '0 || r_decay) begin
                    n_neg   = diff[LVL_EXT_W-1];
                    n_mag   = diff_abs[MUL_A_W-1:0];
                    n_todo  = r_todo & (r_todo - 1'b1);
                    n_decay = 1'b0;
                    n_state = ST_BSTART;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_BSTART: begin
                o_mul_req.start = 1'b1;
                o_mul_req.a     = r_mag;
                o_mul_req.b     = {{(MUL_B_W-W_W){1'b0}}, r_w};
                n_state         = ST_BWAIT;
            end
            ST_BWAIT: begin
                if (i_mul_rsp.done) begin
                    n_level = level_new[AXIS_W-1:0];
                    n_state = ST_PICK;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_value = snapped;
                    n_level     = snapped;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.axis_value = r_out_value;

endmodule

// ===== hdl/axs_checker.sv =====
module axs_checker import axs_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     i_in_ready,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic signed [AXIS_W-1:0] i_axis_value
);

    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_axis_value >= -16'sd16384 && i_axis_value <= 16'sd16384))
        else $error("axis value out of range");

    a_dead_zone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_axis_value == '0 || i_axis_value > DEAD_ZONE ||
                         i_axis_value < -DEAD_ZONE))
        else $error("axis value inside dead zone");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request taken while another is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_axis_value)))
        else $error("stalled result changed");

endmodule

bind axis_input_smoother axs_checker u_axs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_axis_value (o_rsp.axis_value)
);

// ===== verif/tb_top.sv =====
module tb_top import axs_pkg::*; ();

    localparam logic [3:0] F_NONE = 4'b0000;
    localparam logic [3:0] F_PK   = 4'b0001;
    localparam logic [3:0] F_NK   = 4'b0010;
    localparam logic [3:0] F_PB   = 4'b0100;
    localparam logic [3:0] F_NB   = 4'b1000;

    localparam int N_PHASES     = 8;
    localparam int PHASE_TICKS  = 106;
    localparam int QUIET_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 120;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct {
        logic            pos_key;
        logic            neg_key;
        logic            pos_btn;
        logic            neg_btn;
        logic [DT_W-1:0] dt;
        bit              wait_drain;
    } t_tick;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    axs_in_if  in_bus ();
    axs_out_if out_bus ();

    axis_input_smoother dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (in_bus.sink),
        .o_rsp   (out_bus.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_tick                    pending[$];
    t_tick                    cur_tick;
    logic signed [AXIS_W-1:0] levels_due[$];
    logic signed [AXIS_W-1:0] axis_now;
    logic signed [AXIS_W-1:0] want;
    logic [SPD_W-1:0]         rise_cfg;
    logic [SPD_W-1:0]         decay_cfg;
    t_idle_mode               idle_mode;
    int                       n_ticks_queued;
    int                       n_levels_seen;
    int                       n_mismatch;
    int                       quiet_cycles;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [W_W-1:0] tick_weight(logic [DT_W-1:0] dt,
                                                   logic [SPD_W-1:0] speed);
        longint unsigned p;
        p = (64'(dt) * 64'(speed) * 64'd25) >> W_SHIFT;
        return (p > 64'(W_ONE)) ? W_ONE : W_W'(p);
    endfunction

    function automatic logic signed [AXIS_W-1:0] pull_toward(
            logic signed [AXIS_W-1:0] level, logic signed [LVL_EXT_W-1:0] target,
            logic [W_W-1:0] w);
        int              diff;
        longint unsigned mag;
        longint unsigned step;
        diff = int'(target) - int'(level);
        mag  = (diff < 0) ? -diff : diff;
        step = (mag * 64'(w) + 64'd32768) >> STEP_LSB;
        return AXIS_W'((diff < 0) ? int'(level) - int'(step) : int'(level) + int'(step));
    endfunction

    function automatic logic signed [AXIS_W-1:0] next_level(t_tick t);
        logic [W_W-1:0]           w_rise;
        logic signed [AXIS_W-1:0] v;
        w_rise = tick_weight(t.dt, rise_cfg);
        v      = axis_now;
        if (t.pos_key) v = pull_toward(v, TGT_POS, w_rise);
        if (t.neg_key) v = pull_toward(v, TGT_NEG, w_rise);
        if (t.pos_btn) v = pull_toward(v, TGT_POS, w_rise);
        if (t.neg_btn) v = pull_toward(v, TGT_NEG, w_rise);
        if (!(t.pos_key || t.neg_key || t.pos_btn || t.neg_btn))
            v = pull_toward(v, TGT_ZERO, tick_weight(t.dt, decay_cfg));
        if (v >= -DEAD_ZONE && v <= DEAD_ZONE) v = '0;
        return v;
    endfunction

    function automatic bit sender_idles();
        return (idle_mode == IDLE_SEND && $urandom_range(0, 99) < 49) ||
               (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 17);
    endfunction

    function automatic bit receiver_stalls();
        return (idle_mode == IDLE_RECV && $urandom_range(0, 99) < 49) ||
               (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 17);
    endfunction

    function automatic logic [3:0] pick_flags();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return F_NONE;
        if (r < 70) return F_PK << $urandom_range(0, 3);
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic logic [DT_W-1:0] pick_dt();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return DT_W'($urandom_range(0, 2000));
        if (r < 60) return DT_W'($urandom_range(0, 64));
        if (r < 90) return DT_W'($urandom);
        return (r < 95) ? DT_W'(0) : {DT_W{1'b1}};
    endfunction

    function automatic logic [SPD_W-1:0] pick_speed();
        if ($urandom_range(0, 1) == 0) return SPD_W'($urandom_range(0, 65535));
        return SPD_W'($urandom_range(1, 2048));
    endfunction

    task automatic report_mismatch(string msg);
        n_mismatch++;
        if (n_mismatch <= 10) $display("%s", msg);
    endtask

    task automatic add_tick(logic [3:0] flags, logic [DT_W-1:0] dt, bit drain = 1'b0);
        t_tick t;
        t.pos_key    = flags[0];
        t.neg_key    = flags[1];
        t.pos_btn    = flags[2];
        t.neg_btn    = flags[3];
        t.dt         = dt;
        t.wait_drain = drain;
        pending.push_back(t);
        n_ticks_queued++;
    endtask

    // held patterns drive the level to the rails and back through the dead zone
    task automatic queue_random(int count);
        logic [3:0] flags;
        int         run;
        int         mid;
        mid = count / 2;
        while (count > 0) begin
            if ($urandom_range(0, 99) < 80) begin
                flags = pick_flags();
                run   = $urandom_range(1, 24);
            end else begin
                flags = 4'($urandom_range(0, 15));
                run   = 1;
            end
            repeat (run) begin
                if (count > 0) begin
                    add_tick(flags, pick_dt(), count == mid);
                    count--;
                end
            end
        end
    endtask

    task automatic write_speed(logic [0:0] idx, logic [SPD_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << REG_IDX_BIT;
        pwdata  <= CFG_DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_RISE) rise_cfg = val;
        else decay_cfg = val;
    endtask

    task automatic wait_drained();
        while (n_levels_seen < n_ticks_queued) @(posedge i_clk);
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                axis_now = next_level(cur_tick);
                levels_due.push_back(axis_now);
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (pending.size() != 0 && !sender_idles() &&
                        !(pending[0].wait_drain && levels_due.size() != 0)) begin
                    cur_tick                  = pending.pop_front();
                    in_bus.valid              <= 1'b1;
                    in_bus.pos_key_pressed    <= cur_tick.pos_key;
                    in_bus.neg_key_pressed    <= cur_tick.neg_key;
                    in_bus.pos_button_pressed <= cur_tick.pos_btn;
                    in_bus.neg_button_pressed <= cur_tick.neg_btn;
                    in_bus.delta_time         <= cur_tick.dt;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                n_levels_seen++;
                if (levels_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected axis_value %0d",
                                              out_bus.axis_value));
                end else begin
                    want = levels_due.pop_front();
                    if (out_bus.axis_value !== want)
                        report_mismatch($sformatf("axis_value mismatch: expected %0d, got %0d",
                                                  want, out_bus.axis_value));
                end
            end
            out_bus.ready <= !receiver_stalls();
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (in_bus.valid && in_bus.ready) ||
                (out_bus.valid && out_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [SPD_W-1:0] rise_v;
        logic [SPD_W-1:0] decay_v;
        i_rst_n                   = 1'b0;
        psel                      = 1'b0;
        penable                   = 1'b0;
        pwrite                    = 1'b0;
        paddr                     = '0;
        pwdata                    = '0;
        in_bus.valid              = 1'b0;
        in_bus.pos_key_pressed    = 1'b0;
        in_bus.neg_key_pressed    = 1'b0;
        in_bus.pos_button_pressed = 1'b0;
        in_bus.neg_button_pressed = 1'b0;
        in_bus.delta_time         = '0;
        out_bus.ready             = 1'b0;
        rise_cfg                  = SPEED_RESET;
        decay_cfg                 = SPEED_RESET;
        axis_now                  = '0;
        idle_mode                 = IDLE_NONE;
        n_ticks_queued            = 0;
        n_levels_seen             = 0;
        n_mismatch                = 0;
        quiet_cycles              = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset speeds: zero time, full weight, all flags, slow steps, dead-zone decay
        add_tick(F_NONE, DT_W'(0));
        add_tick(F_PK, {DT_W{1'b1}});
        add_tick(F_PK, DT_W'(0));
        add_tick(F_PK | F_NK | F_PB | F_NB, {DT_W{1'b1}});
        add_tick(F_NONE, {DT_W{1'b1}});
        add_tick(F_PK, DT_W'(100));
        add_tick(F_NB, DT_W'(1));
        add_tick(F_NONE, DT_W'(1));
        repeat (4) add_tick(F_NONE, DT_W'(3000));
        for (int f = 0; f < 16; f++) add_tick(4'(f), DT_W'(2500 + f * 37));
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: begin
                    rise_v  = '1;
                    decay_v = '1;
                end
                1: begin
                    rise_v  = '0;
                    decay_v = SPD_W'(700);
                end
                2: begin
                    rise_v  = SPD_W'(1200);
                    decay_v = '0;
                end
                3: begin
                    rise_v  = SPD_W'(1);
                    decay_v = SPD_W'(1);
                end
                default: begin
                    rise_v  = pick_speed();
                    decay_v = pick_speed();
                end
            endcase
            write_speed(REG_RISE, rise_v);
            write_speed(REG_DECAY, decay_v);
            idle_mode = t_idle_mode'(p % 4);
            queue_random(PHASE_TICKS);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (levels_due.size() != 0)
            report_mismatch($sformatf("%0d axis values never arrived", levels_due.size()));
        if (n_mismatch == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
